[hdl/rpg_pkg.sv]
// Shared types and constants for the resource pressure gate.
package rpg_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned NUM_REGS   = 7;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned REG_IDX_W  = 3;
   localparam int unsigned REQ_DATA_W = 168;
   localparam int unsigned RSP_DATA_W = 136;

   // Register indexes (byte address = 4 * index)
   localparam logic [REG_IDX_W-1:0] REG_OVERFLOW_LIMIT = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BLOCKED_LIMIT  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DRAW_LIMIT     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FLUSH_LIMIT    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_PRESSURE_HOLD  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_MIC_HOLD       = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CAM_COOLDOWN   = 3'd6;

   // Register reset values
   localparam logic [WORD_W-1:0] RST_OVERFLOW_LIMIT = 32'd1;
   localparam logic [WORD_W-1:0] RST_BLOCKED_LIMIT  = 32'd1;
   localparam logic [WORD_W-1:0] RST_DRAW_LIMIT     = 32'd40000;
   localparam logic [WORD_W-1:0] RST_FLUSH_LIMIT    = 32'd40000;
   localparam logic [WORD_W-1:0] RST_PRESSURE_HOLD  = 32'd2000;
   localparam logic [WORD_W-1:0] RST_MIC_HOLD       = 32'd1000;
   localparam logic [WORD_W-1:0] RST_CAM_COOLDOWN   = 32'd1000;

   typedef enum logic [1:0] {
      MODE_UPDATE  = 2'd0,
      MODE_CAMERA  = 2'd1,
      MODE_PROFILE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PROFILE_GRAPHICS = 2'd0,
      PROFILE_MIC      = 2'd1,
      PROFILE_CAMERA   = 2'd2
   } profile_type;

   // Spare profile code, taken as graphics focus
   localparam logic [1:0] PROFILE_UNUSED = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] overflow_limit;
      logic [WORD_W-1:0] blocked_limit;
      logic [WORD_W-1:0] draw_limit;
      logic [WORD_W-1:0] flush_limit;
      logic [WORD_W-1:0] pressure_hold;
      logic [WORD_W-1:0] mic_hold;
      logic [WORD_W-1:0] cam_cooldown;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [WORD_W-1:0] overflow_count;
      logic [WORD_W-1:0] blocked_count;
      logic [WORD_W-1:0] draw_peak_us;
      logic [WORD_W-1:0] flush_peak_us;
      logic [WORD_W-1:0] time_ms;
      logic [1:0]        profile_choice;
   } item_type;

   typedef struct packed {
      logic              pressure_active;
      logic              mic_run;
      logic              camera_permitted;
      logic              camera_granted;
      logic [WORD_W-1:0] ovf_increase;
      logic [WORD_W-1:0] blk_increase;
      logic [WORD_W-1:0] granted_total;
      logic [WORD_W-1:0] denied_total;
   } result_type;

endpackage

[hdl/rpg_csr.sv]
// Configuration register file with APB-style access.
module rpg_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rpg_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rpg_pkg::WORD_W-1:0]       csr_pwdata,
   output logic [rpg_pkg::WORD_W-1:0]       csr_prdata,
   output logic                             csr_pready,
   output rpg_pkg::cfg_type                 cfg
);

   rpg_pkg::cfg_type              cfg_ff;
   rpg_pkg::cfg_type              cfg_in;
   logic [rpg_pkg::REG_IDX_W-1:0] reg_idx;
   logic                          wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[rpg_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rpg_pkg::REG_OVERFLOW_LIMIT: cfg_in.overflow_limit = csr_pwdata;
            rpg_pkg::REG_BLOCKED_LIMIT:  cfg_in.blocked_limit  = csr_pwdata;
            rpg_pkg::REG_DRAW_LIMIT:     cfg_in.draw_limit     = csr_pwdata;
            rpg_pkg::REG_FLUSH_LIMIT:    cfg_in.flush_limit    = csr_pwdata;
            rpg_pkg::REG_PRESSURE_HOLD:  cfg_in.pressure_hold  = csr_pwdata;
            rpg_pkg::REG_MIC_HOLD:       cfg_in.mic_hold       = csr_pwdata;
            rpg_pkg::REG_CAM_COOLDOWN:   cfg_in.cam_cooldown   = csr_pwdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rpg_pkg::REG_OVERFLOW_LIMIT: csr_prdata = cfg_ff.overflow_limit;
         rpg_pkg::REG_BLOCKED_LIMIT:  csr_prdata = cfg_ff.blocked_limit;
         rpg_pkg::REG_DRAW_LIMIT:     csr_prdata = cfg_ff.draw_limit;
         rpg_pkg::REG_FLUSH_LIMIT:    csr_prdata = cfg_ff.flush_limit;
         rpg_pkg::REG_PRESSURE_HOLD:  csr_prdata = cfg_ff.pressure_hold;
         rpg_pkg::REG_MIC_HOLD:       csr_prdata = cfg_ff.mic_hold;
         rpg_pkg::REG_CAM_COOLDOWN:   csr_prdata = cfg_ff.cam_cooldown;
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overflow_limit <= rpg_pkg::RST_OVERFLOW_LIMIT;
         cfg_ff.blocked_limit  <= rpg_pkg::RST_BLOCKED_LIMIT;
         cfg_ff.draw_limit     <= rpg_pkg::RST_DRAW_LIMIT;
         cfg_ff.flush_limit    <= rpg_pkg::RST_FLUSH_LIMIT;
         cfg_ff.pressure_hold  <= rpg_pkg::RST_PRESSURE_HOLD;
         cfg_ff.mic_hold       <= rpg_pkg::RST_MIC_HOLD;
         cfg_ff.cam_cooldown   <= rpg_pkg::RST_CAM_COOLDOWN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/rpg_engine.sv]
// Gate state and single-pass update logic for one request.
module rpg_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  rpg_pkg::item_type    item,
   input  rpg_pkg::cfg_type     cfg,
   output rpg_pkg::result_type  result
);

   localparam int unsigned W = rpg_pkg::WORD_W;

   logic [W-1:0] prev_ov_ff,  prev_ov_in;
   logic [W-1:0] prev_bl_ff,  prev_bl_in;
   logic [1:0]   profile_ff,  profile_in;
   logic [W-1:0] last_time_ff, last_time_in;
   logic [W-1:0] pdl_ff,      pdl_in;
   logic         pflag_ff,    pflag_in;
   logic         mic_ff,      mic_in;
   logic [W-1:0] mdl_ff,      mdl_in;
   logic         cam_ff,      cam_in;
   logic [W-1:0] cool_ff,     cool_in;
   logic [W-1:0] grants_ff,   grants_in;
   logic [W-1:0] denies_ff,   denies_in;
   logic [W-1:0] od_ff,       od_in;
   logic [W-1:0] bd_ff,       bd_in;
   logic         granted;

   // Update-path terms, all computed side by side from registered values
   logic [W-1:0] ov_delta, bl_delta;
   logic         hit;
   logic [W-1:0] hold_sum, neg_hold, t_minus_pdl, t_minus_mdl, t_minus_cool;
   logic [W-1:0] lt_minus_cool, mic_sum, cool_sum;
   logic [1:0]   new_profile;

   assign ov_delta = (item.overflow_count >= prev_ov_ff) ?
                     (item.overflow_count - prev_ov_ff) : item.overflow_count;
   assign bl_delta = (item.blocked_count >= prev_bl_ff) ?
                     (item.blocked_count - prev_bl_ff) : item.blocked_count;

   // Threshold on the delta folded into the compare so the chain stays short
   assign hit = (ov_delta >= cfg.overflow_limit) || (bl_delta >= cfg.blocked_limit) ||
                (item.draw_peak_us >= cfg.draw_limit) ||
                (item.flush_peak_us >= cfg.flush_limit);

   assign hold_sum      = item.time_ms + cfg.pressure_hold;
   assign neg_hold      = '0 - cfg.pressure_hold;   // t - (t + hold)
   assign t_minus_pdl   = item.time_ms - pdl_ff;
   assign t_minus_mdl   = item.time_ms - mdl_ff;
   assign t_minus_cool  = item.time_ms - cool_ff;
   assign lt_minus_cool = last_time_ff - cool_ff;
   assign mic_sum       = item.time_ms + cfg.mic_hold;
   assign cool_sum      = last_time_ff + cfg.cam_cooldown;
   assign new_profile   = (item.profile_choice == rpg_pkg::PROFILE_UNUSED) ?
                          rpg_pkg::PROFILE_GRAPHICS : item.profile_choice;

   always_comb begin
      prev_ov_in   = prev_ov_ff;
      prev_bl_in   = prev_bl_ff;
      profile_in   = profile_ff;
      last_time_in = last_time_ff;
      pdl_in       = pdl_ff;
      pflag_in     = pflag_ff;
      mic_in       = mic_ff;
      mdl_in       = mdl_ff;
      cam_in       = cam_ff;
      cool_in      = cool_ff;
      grants_in    = grants_ff;
      denies_in    = denies_ff;
      od_in        = od_ff;
      bd_in        = bd_ff;
      granted      = 1'b0;
      case (item.mode)
         rpg_pkg::MODE_UPDATE: begin
            prev_ov_in   = item.overflow_count;
            prev_bl_in   = item.blocked_count;
            last_time_in = item.time_ms;
            od_in        = ov_delta;
            bd_in        = bl_delta;
            // zero deadline means none; held while deadline is strictly ahead
            if (hit) begin
               pdl_in   = hold_sum;
               pflag_in = (hold_sum != '0) && neg_hold[W-1];
            end else begin
               pflag_in = (pdl_ff != '0) && t_minus_pdl[W-1];
            end
            if (profile_ff == rpg_pkg::PROFILE_MIC) begin
               mic_in = 1'b1;
               mdl_in = mic_sum;
            end else if (mic_ff && !t_minus_mdl[W-1]) begin
               mic_in = 1'b0;
            end
            cam_in = (profile_ff == rpg_pkg::PROFILE_CAMERA) && !pflag_in &&
                     !t_minus_cool[W-1];
         end
         rpg_pkg::MODE_CAMERA: begin
            if (cam_ff) begin
               granted   = 1'b1;
               grants_in = grants_ff + 32'd1;
               cool_in   = cool_sum;
               cam_in    = 1'b0;
            end else begin
               denies_in = denies_ff + 32'd1;
            end
         end
         rpg_pkg::MODE_PROFILE: begin
            profile_in = new_profile;
            cam_in = (new_profile == rpg_pkg::PROFILE_CAMERA) && !pflag_ff &&
                     !lt_minus_cool[W-1];
         end
         default: begin
            // unused mode: state unchanged
         end
      endcase
   end

   always_comb begin
      result.pressure_active  = pflag_in;
      result.mic_run          = mic_in;
      result.camera_permitted = cam_in;
      result.camera_granted   = granted;
      result.ovf_increase     = od_in;
      result.blk_increase     = bd_in;
      result.granted_total    = grants_in;
      result.denied_total     = denies_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ov_ff   <= '0;
         prev_bl_ff   <= '0;
         profile_ff   <= rpg_pkg::PROFILE_GRAPHICS;
         last_time_ff <= '0;
         pdl_ff       <= '0;
         pflag_ff     <= 1'b0;
         mic_ff       <= 1'b0;
         mdl_ff       <= '0;
         cam_ff       <= 1'b0;
         cool_ff      <= '0;
         grants_ff    <= '0;
         denies_ff    <= '0;
         od_ff        <= '0;
         bd_ff        <= '0;
      end else if (fire) begin
         prev_ov_ff   <= prev_ov_in;
         prev_bl_ff   <= prev_bl_in;
         profile_ff   <= profile_in;
         last_time_ff <= last_time_in;
         pdl_ff       <= pdl_in;
         pflag_ff     <= pflag_in;
         mic_ff       <= mic_in;
         mdl_ff       <= mdl_in;
         cam_ff       <= cam_in;
         cool_ff      <= cool_in;
         grants_ff    <= grants_in;
         denies_ff    <= denies_in;
         od_ff        <= od_in;
         bd_ff        <= bd_in;
      end
   end

   // Permission never survives while pressure holds or outside camera profile
   a_cam_needs_profile: assert property (@(posedge clock) disable iff (reset)
      cam_ff |-> (!pflag_ff && profile_ff == rpg_pkg::PROFILE_CAMERA))
      else $error("camera permission without camera profile or under pressure");

   // Pressure can only be held against a real deadline
   a_pressure_has_deadline: assert property (@(posedge clock) disable iff (reset)
      pflag_ff |-> (pdl_ff != '0))
      else $error("pressure flag set with no deadline");

   // A grant bumps the grant count by one and drops permission
   a_grant_counts: assert property (@(posedge clock) disable iff (reset)
      (fire && granted) |=> (grants_ff == $past(grants_ff) + 32'd1) && !cam_ff)
      else $error("grant not counted or permission kept");

   // Exactly one of the two counters moves on a camera request
   a_camera_one_count: assert property (@(posedge clock) disable iff (reset)
      (fire && item.mode == rpg_pkg::MODE_CAMERA) |=>
      ($countones({grants_ff != $past(grants_ff), denies_ff != $past(denies_ff)}) == 1))
      else $error("camera request did not move exactly one counter");

endmodule

[hdl/resource_pressure_gate.sv]
// Top level of the resource pressure gate: stream handshake, registers, CSR.
//
//  channel   dir  handshake        payload
//  req_      in   tvalid/tready    tuser = mode, tdata = counters, peaks, time, profile
//  rsp_      out  tvalid/tready    tdata = flags, increases, grant and denial totals
//  csr_      in   APB psel/penable 7 x 32-bit registers at byte address 4*i
//
//  One request per cycle sustained while rsp_tready stays high; a result is offered
//  once its request has passed the input register, then the result register.
//  The combinational state update between the two registers sets the rate.
//  Synchronous reset clears all gate state and loads register defaults.
//  A stalled result holds the result register; the input register still
//  takes one more request, after which req_tready follows rsp_tready.
module resource_pressure_gate (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] mode
   input  logic [1:0]                          req_tuser,
   // [31:0] overflow_count, [63:32] blocked_count, [95:64] draw_peak_us,
   // [127:96] flush_peak_us, [159:128] time_ms, [161:160] profile_choice,
   // [167:162] zero
   input  logic [rpg_pkg::REQ_DATA_W-1:0]      req_tdata,
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] pressure_active, [1] mic_run, [2] camera_permitted, [3] camera_granted,
   // [35:4] ovf_increase, [67:36] blk_increase, [99:68] granted_total,
   // [131:100] denied_total, [135:132] zero
   output logic [rpg_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rpg_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [rpg_pkg::WORD_W-1:0]          csr_pwdata,
   output logic [rpg_pkg::WORD_W-1:0]          csr_prdata,
   output logic                                csr_pready
);

   rpg_pkg::cfg_type    cfg;
   rpg_pkg::item_type   req_item;
   rpg_pkg::result_type result;

   logic                in_valid_ff, in_valid_in;
   rpg_pkg::item_type   in_item_ff;
   logic                out_valid_ff, out_valid_in;
   rpg_pkg::result_type out_result_ff;
   logic                advance;
   logic                req_take;

   // unpack the request
   assign req_item.mode           = req_tuser;
   assign req_item.overflow_count = req_tdata[31:0];
   assign req_item.blocked_count  = req_tdata[63:32];
   assign req_item.draw_peak_us   = req_tdata[95:64];
   assign req_item.flush_peak_us  = req_tdata[127:96];
   assign req_item.time_ms        = req_tdata[159:128];
   assign req_item.profile_choice = req_tdata[161:160];

   // the held request moves on whenever the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   rpg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rpg_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload flops, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        out_result_ff.denied_total,
                        out_result_ff.granted_total,
                        out_result_ff.blk_increase,
                        out_result_ff.ovf_increase,
                        out_result_ff.camera_granted,
                        out_result_ff.camera_permitted,
                        out_result_ff.mic_run,
                        out_result_ff.pressure_active};

   // A held request is never dropped while the result side stalls
   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("pending request lost");

   // A request moves to the result register only when it has room
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      advance |-> (!out_valid_ff || rsp_tready))
      else $error("result overwritten before taken");

   // A granted result never reports permission still open
   a_grant_closes: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_result_ff.camera_granted) |-> !out_result_ff.camera_permitted)
      else $error("grant reported with permission still set");

endmodule
